// File: hdl/vqm_pkg.sv
package vqm_pkg;

	// Descriptor store geometry
	localparam int FIFO_DEPTH = 1024;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// Phantom queue arithmetic widths
	localparam int TIME_W  = 48;
	localparam int VLEN_W  = 40;
	localparam int DRAIN_W = TIME_W - 3;
	localparam int THR_W   = 27;
	localparam int MAXP_W  = 11;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = THR_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MARK_THRESHOLD = 1'd0,
		CFG_MAX_PACKETS    = 1'd1
	} cfg_idx_t;

	localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(768000);
	localparam logic [MAXP_W-1:0] MAXP_RESET = MAXP_W'(1000);

	typedef enum logic [1:0] {
		KIND_ENQUEUE = 2'd0,
		KIND_DEQUEUE = 2'd1,
		KIND_PEEK    = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		STATUS_ENQUEUED = 3'd0,
		STATUS_DROPPED  = 3'd1,
		STATUS_DEQUEUED = 3'd2,
		STATUS_PEEKED   = 3'd3,
		STATUS_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_LEN,
		ST_ENQ,
		ST_READ
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [47:0] time_ns;
		logic [15:0] pkt_size;
		logic [15:0] pkt_tag;
		logic        ecn_capable;
	} in_req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] item_tag;
		logic [15:0] item_size;
		logic        item_marked;
	} result_t;

	// One stored descriptor
	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] size;
		logic        marked;
	} desc_t;

	typedef struct packed {
		logic rd_en;
		logic push;
		logic pop;
	} fifo_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
	} fifo_stat_t;

endpackage

// File: hdl/vqm_fifo.sv
module vqm_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  vqm_pkg::fifo_ctrl_t ctrl,
	input  vqm_pkg::desc_t     wr_data,
	output vqm_pkg::desc_t     rd_data,
	output vqm_pkg::fifo_stat_t stat
);
	import vqm_pkg::*;

	desc_t            mem [FIFO_DEPTH];
	desc_t            rd_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Write the tail entry on a push
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail_q] <= wr_data;
		end
	end

	// Read the head entry, registered
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_q <= mem[head_q];
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.push) begin
				tail_q <= ptr_next(tail_q);
			end
			if (ctrl.pop) begin
				head_q <= ptr_next(head_q);
			end
			case ({ctrl.push, ctrl.pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_data    = rd_q;
	assign stat.count = count_q;

endmodule

// File: hdl/virtual_queue_ecn_marker_fifo.sv
// Packet descriptor FIFO with a phantom queue for ECN marking.
// Input channel (in_valid / in_stall / in_data) carries one request: an
// enqueue, a dequeue or a peek at the head. Output channel (out_valid /
// out_stall / out_data) returns exactly one result per request, in order.
// The phantom queue drains one byte per 8 ns of elapsed time on each
// enqueue, then grows by the packet size, whether or not the packet is kept.
// Configuration (cfg_we / cfg_index / cfg_data) sets the mark threshold and
// the packet limit; write it only while no request is in flight.
// Steps: an enqueue passes through the time delta, the drained length, then
// update, store write and result load; a dequeue or peek passes through the
// registered read of the descriptor memory before its result is loaded.
// One request is in flight at a time, so a new request is taken only once the last is done.
// The result register frees the input side: a new request is taken while a
// result still waits. If the receiver stalls and a second result is ready,
// the block holds that result in its final step until the register frees.
// Reset clears the phantom queue, last arrival time, pointers and count;
// the descriptor memory is not cleared and needs no clearing pass.
module virtual_queue_ecn_marker_fifo (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  vqm_pkg::in_req_t                 in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output vqm_pkg::result_t                 out_data,
	input  logic                             cfg_we,
	input  logic [vqm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vqm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import vqm_pkg::*;

	state_t              state_q, state_d;
	in_req_t             req_q;
	logic [DRAIN_W-1:0]  drained_s2;
	logic [VLEN_W-1:0]   qsize_s3;
	logic [VLEN_W-1:0]   vlen_q;
	logic [TIME_W-1:0]   last_q;
	logic [THR_W-1:0]    thr_q;
	logic [MAXP_W-1:0]   maxp_q;
	result_t             out_q;
	logic                out_valid_q;

	logic                accept;
	logic                out_load;
	result_t             result_d;
	fifo_ctrl_t          fifo_ctrl;
	fifo_stat_t          fifo_stat;
	desc_t               wr_desc;
	desc_t               rd_desc;
	logic [TIME_W-1:0]   elapsed;
	logic [VLEN_W:0]     vsum;
	logic [VLEN_W-1:0]   vlen_next;
	logic                full;
	logic                mark;
	logic                empty;

	vqm_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (fifo_ctrl),
		.wr_data (wr_desc),
		.rd_data (rd_desc),
		.stat    (fifo_stat)
	);

	// Datapath terms for the enqueue steps
	assign elapsed   = req_q.time_ns - last_q;
	assign vsum      = {1'b0, qsize_s3} + (VLEN_W + 1)'(req_q.pkt_size);
	assign vlen_next = vsum[VLEN_W] ? '1 : vsum[VLEN_W-1:0];
	assign mark      = req_q.ecn_capable && (qsize_s3 >= VLEN_W'(thr_q));
	assign full      = (32'(fifo_stat.count) >= 32'(FIFO_DEPTH)) ||
	                   (32'(fifo_stat.count) >= 32'(maxp_q));
	assign empty     = (fifo_stat.count == '0);

	assign wr_desc.tag    = req_q.pkt_tag;
	assign wr_desc.size   = req_q.pkt_size;
	assign wr_desc.marked = mark;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Sequence one request, build its result
	always_comb begin
		state_d        = state_q;
		out_load       = 1'b0;
		fifo_ctrl      = '0;
		result_d       = '0;
		result_d.status = STATUS_EMPTY;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_data.kind == KIND_ENQUEUE) begin
						state_d = ST_DRAIN;
					end else begin
						state_d         = ST_READ;
						fifo_ctrl.rd_en = 1'b1;
					end
				end
			end
			ST_DRAIN: state_d = ST_LEN;
			ST_LEN:   state_d = ST_ENQ;
			ST_ENQ: begin
				if (full) begin
					result_d.status = STATUS_DROPPED;
				end else begin
					result_d.status      = STATUS_ENQUEUED;
					result_d.item_tag    = req_q.pkt_tag;
					result_d.item_size   = req_q.pkt_size;
					result_d.item_marked = mark;
				end
				out_load = !out_valid_q || !out_stall;
				if (out_load) begin
					fifo_ctrl.push = !full;
					state_d        = ST_IDLE;
				end
			end
			ST_READ: begin
				if (!empty) begin
					result_d.status      = (req_q.kind == KIND_DEQUEUE) ?
					                       STATUS_DEQUEUED : STATUS_PEEKED;
					result_d.item_tag    = rd_desc.tag;
					result_d.item_size   = rd_desc.size;
					result_d.item_marked = rd_desc.marked;
				end
				out_load = !out_valid_q || !out_stall;
				if (out_load) begin
					fifo_ctrl.pop = !empty && (req_q.kind == KIND_DEQUEUE);
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the request, the enqueue intermediates and the result
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
		end
		if (state_q == ST_DRAIN) begin
			drained_s2 <= (req_q.time_ns >= last_q) ? elapsed[TIME_W-1:3] : '0;
		end
		if (state_q == ST_LEN) begin
			qsize_s3 <= (DRAIN_W'(vlen_q) > drained_s2) ?
			            vlen_q - drained_s2[VLEN_W-1:0] : '0;
		end
		if (out_load) begin
			out_q <= result_d;
		end
	end

	// Phantom queue state, configuration and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q      <= '0;
			last_q      <= '0;
			thr_q       <= THR_RESET;
			maxp_q      <= MAXP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DRAIN) begin
				last_q <= req_q.time_ns;
			end
			if (out_load && state_q == ST_ENQ) begin
				vlen_q <= vlen_next;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MARK_THRESHOLD: thr_q  <= cfg_data;
					CFG_MAX_PACKETS:    maxp_q <= cfg_data[MAXP_W-1:0];
					default:            thr_q  <= thr_q;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: hdl/vqm_checker.sv
module vqm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input vqm_pkg::result_t               out_data
);
	import vqm_pkg::*;

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn under stall");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("result changed under stall");

	// One request in flight: the input side closes after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while one is in flight");

	// Drop and empty results carry no descriptor
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STATUS_DROPPED ||
		              out_data.status == STATUS_EMPTY)
		|-> (out_data.item_tag == '0 && out_data.item_size == '0 &&
		     !out_data.item_marked))
		else $error("drop or empty result with descriptor fields set");

endmodule

bind virtual_queue_ecn_marker_fifo vqm_checker u_vqm_checker (.*);

// File: dv/tb_virtual_queue_ecn_marker_fifo.sv
`timescale 1ns / 100ps

module tb_virtual_queue_ecn_marker_fifo;
	import vqm_pkg::*;

	// Kind code outside the enum; the block treats it as a peek
	localparam logic [1:0] KIND_PEEK_ALIAS = 2'd3;
	localparam int SETTLE_CYCLES = 12;
	localparam int WATCHDOG_NS   = 20_000_000;

	// Mirror of the descriptor FIFO and phantom queue, with result matching
	class ecn_fifo_mirror;
		logic [THR_W-1:0]  thr;
		logic [MAXP_W-1:0] pkt_limit;
		logic [VLEN_W-1:0] virt_len;
		logic [TIME_W-1:0] last_arrival;
		desc_t             slots[FIFO_DEPTH];
		int                rd_ptr, wr_ptr, held;
		result_t           due_results[$];
		int                errors, checked;
		int                n_enq, n_marked, n_drop, n_deq, n_peek, n_empty;

		function new();
			thr          = THR_RESET;
			pkt_limit    = MAXP_RESET;
			virt_len     = '0;
			last_arrival = '0;
			rd_ptr = 0; wr_ptr = 0; held = 0;
			errors = 0; checked = 0;
			n_enq = 0; n_marked = 0; n_drop = 0; n_deq = 0; n_peek = 0; n_empty = 0;
		endfunction

		function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_MARK_THRESHOLD)
				thr = val[THR_W-1:0];
			else
				pkt_limit = val[MAXP_W-1:0];
		endfunction

		// Work out the single result of an accepted request
		function void take_request(in_req_t r);
			result_t           res;
			desc_t             d;
			logic [TIME_W-1:0] elapsed;
			logic [DRAIN_W-1:0] drained;
			logic [VLEN_W-1:0] backlog;
			logic [VLEN_W:0]   grown;
			int                lim;
			res = '0;
			if (r.kind == KIND_ENQUEUE) begin
				// Drain first, then grow by the packet even if it is dropped
				elapsed = (r.time_ns >= last_arrival) ? r.time_ns - last_arrival : '0;
				drained = elapsed[TIME_W-1:3];
				backlog = (DRAIN_W'(virt_len) > drained) ?
					VLEN_W'(DRAIN_W'(virt_len) - drained) : '0;
				grown = {1'b0, backlog} + (VLEN_W+1)'(r.pkt_size);
				last_arrival = r.time_ns;
				virt_len = grown[VLEN_W] ? {VLEN_W{1'b1}} : grown[VLEN_W-1:0];
				lim = (pkt_limit < FIFO_DEPTH) ? int'(pkt_limit) : FIFO_DEPTH;
				if (held >= lim) begin
					res.status = STATUS_DROPPED;
				end else begin
					d.tag    = r.pkt_tag;
					d.size   = r.pkt_size;
					d.marked = r.ecn_capable && (backlog >= VLEN_W'(thr));
					slots[wr_ptr] = d;
					wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
					held++;
					res.status = STATUS_ENQUEUED;
					res.item_tag = d.tag; res.item_size = d.size; res.item_marked = d.marked;
				end
			end else if (held == 0) begin
				res.status = STATUS_EMPTY;
			end else begin
				d = slots[rd_ptr];
				res.item_tag = d.tag; res.item_size = d.size; res.item_marked = d.marked;
				if (r.kind == KIND_DEQUEUE) begin
					res.status = STATUS_DEQUEUED;
					rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
					held--;
				end else begin
					res.status = STATUS_PEEKED;
				end
			end
			due_results.push_back(res);
		endfunction

		task flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
			errors++;
			$display("%0t: result %0d %s: got %0h, expected %0h",
				$time, checked, what, got, want);
		endtask

		// Compare one delivered result with the oldest one due
		task match_result(result_t got);
			result_t exp;
			if (due_results.size() == 0) begin
				flag_mismatch("arrived with none outstanding", 16'(got.status), 16'd0);
			end else begin
				exp = due_results.pop_front();
				if (got.status !== exp.status)
					flag_mismatch("status", 16'(got.status), 16'(exp.status));
				if (got.item_tag !== exp.item_tag)
					flag_mismatch("item_tag", got.item_tag, exp.item_tag);
				if (got.item_size !== exp.item_size)
					flag_mismatch("item_size", got.item_size, exp.item_size);
				if (got.item_marked !== exp.item_marked)
					flag_mismatch("item_marked", 16'(got.item_marked), 16'(exp.item_marked));
				case (exp.status)
					STATUS_ENQUEUED: begin
						n_enq++;
						if (exp.item_marked) n_marked++;
					end
					STATUS_DROPPED:  n_drop++;
					STATUS_DEQUEUED: n_deq++;
					STATUS_PEEKED:   n_peek++;
					default:         n_empty++;
				endcase
			end
			checked++;
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_req_t          in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	result_t          out_data;
	logic             cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ecn_fifo_mirror    mirror;
	logic [TIME_W-1:0] cur_time = '0;
	bit                sender_idles = 1'b1;
	int                burst_left = 0;
	int                stall_mode = 0, mode_left = 0, run_left = 0;

	virtual_queue_ecn_marker_fifo u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Receiver back-pressure: free flow, random stalls, or long stall runs
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(2);
			mode_left  = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(3) == 0);
			default: begin
				if (run_left == 0) begin
					out_stall <= ~out_stall;
					run_left = out_stall ? $urandom_range(1, 3) : $urandom_range(1, 20);
				end else begin
					run_left--;
				end
			end
		endcase
	end

	// Check every result taken by the receiver
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0)
			mirror.match_result(out_data);
	end

	function automatic in_req_t make_req(logic [1:0] kind, logic [47:0] t,
			logic [15:0] size, logic [15:0] tag, logic ecn);
		in_req_t r;
		r.kind        = kind_t'(kind);
		r.time_ns     = t;
		r.pkt_size    = size;
		r.pkt_tag     = tag;
		r.ecn_capable = ecn;
		return r;
	endfunction

	// Random request; time mostly creeps forward, sometimes stalls, jumps or goes back
	function automatic in_req_t random_req(int enq_pct);
		logic [1:0]  kind;
		logic [15:0] size;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 40)
			cur_time = cur_time + 48'($urandom_range(0, 2000));
		else if (pick < 70)
			cur_time = cur_time + 48'($urandom_range(0, 60000));
		else if (pick < 80)
			cur_time = cur_time;
		else if (pick < 88)
			cur_time = cur_time + 48'($urandom);
		else if (pick < 94)
			cur_time = cur_time - 48'($urandom_range(1, 50000));
		else
			cur_time = {16'($urandom), 32'($urandom)};
		pick = $urandom_range(9);
		size = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
		if ($urandom_range(99) < enq_pct) begin
			kind = KIND_ENQUEUE;
		end else begin
			pick = $urandom_range(9);
			kind = (pick < 6) ? KIND_DEQUEUE : (pick < 9) ? KIND_PEEK : KIND_PEEK_ALIAS;
		end
		return make_req(kind, cur_time, size, 16'($urandom), 1'($urandom));
	endfunction

	// Offer one request, idling between bursts, and hold it until taken
	task automatic push_request(input in_req_t r);
		if (sender_idles && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (in_stall !== 1'b0);
		mirror.take_request(r);
		if (burst_left > 0) burst_left--;
	endtask

	// Leave the input idle until every result due has been taken
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (mirror.due_results.size() != 0) @(posedge clk);
	endtask

	// Caller lowers cfg_we after the last write of a group
	task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		mirror.set_register(idx, val);
	endtask

	task automatic run_phase(input logic [THR_W-1:0] thr, input logic [MAXP_W-1:0] maxp,
			input int enq_pct, input int n_items, input bit idles);
		write_register(CFG_MARK_THRESHOLD, thr);
		write_register(CFG_MAX_PACKETS, CFG_DATA_W'(maxp));
		cfg_we <= 1'b0;
		sender_idles = idles;
		repeat (n_items) push_request(random_req(enq_pct));
		wait_drained();
	endtask

	initial begin
		#(WATCHDOG_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		mirror = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset thresholds: empty replies, field extremes, alias peek
		push_request(make_req(KIND_DEQUEUE, '0, '0, '0, 1'b0));
		push_request(make_req(KIND_PEEK, '1, '1, '1, 1'b1));
		push_request(make_req(KIND_PEEK_ALIAS, '0, '0, '0, 1'b0));
		push_request(make_req(KIND_ENQUEUE, '0, 16'h0000, 16'h0000, 1'b0));
		push_request(make_req(KIND_ENQUEUE, '0, 16'hFFFF, 16'hFFFF, 1'b1));
		push_request(make_req(KIND_PEEK, '0, '0, '0, 1'b0));
		push_request(make_req(KIND_PEEK_ALIAS, '0, '0, '0, 1'b0));
		push_request(make_req(KIND_DEQUEUE, '0, '0, '0, 1'b0));
		// Largest time drains everything, then time goes back and nothing drains
		push_request(make_req(KIND_ENQUEUE, '1, 16'd1234, 16'h5A5A, 1'b1));
		push_request(make_req(KIND_ENQUEUE, 48'd16, 16'd777, 16'hA5A5, 1'b1));
		// Pile up at a fixed time until the reset threshold is crossed
		repeat (13) push_request(make_req(KIND_ENQUEUE, 48'd16, 16'hFFFF, 16'($urandom), 1'b1));
		push_request(make_req(KIND_DEQUEUE, '0, '0, '0, 1'b0));
		push_request(make_req(KIND_PEEK, '0, '0, '0, 1'b0));
		wait_drained();

		// Random phases over a range of thresholds and packet limits
		run_phase('0, 11'd1, 50, 30, 1'b1);
		run_phase(27'd5000, 11'd6, 55, 50, 1'b1);
		run_phase(27'd76800000, 11'd0, 60, 20, 1'b1);
		run_phase(27'd300000, 11'd2047, 100, 1030, 1'b0);
		run_phase(27'h7FFFFFF, 11'd1024, 15, 50, 1'b1);
		run_phase(27'($urandom_range(0, 200000)), 11'($urandom_range(1, 16)), 50, 30, 1'b1);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mirror.due_results.size() != 0)
			mirror.flag_mismatch("left outstanding", 16'(mirror.due_results.size()), 16'd0);
		$display("Checked %0d results: %0d enqueued (%0d marked), %0d dropped,",
			mirror.checked, mirror.n_enq, mirror.n_marked, mirror.n_drop);
		$display("  %0d dequeued, %0d peeked, %0d empty; %0d mismatches",
			mirror.n_deq, mirror.n_peek, mirror.n_empty, mirror.errors);
		if (mirror.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
